[hdl/dotstf_pkg.sv]
// ----------------------------------------------------------------------------
// dotstf_pkg
// Shared constants and types for the POP3 dot-stuffing line encoder.
// ----------------------------------------------------------------------------
package dotstf_pkg;

   localparam int unsigned BURST_DEPTH = 7;
   localparam int unsigned COUNT_WIDTH = $clog2(BURST_DEPTH + 1);
   localparam int unsigned INDEX_WIDTH = $clog2(BURST_DEPTH);
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_DOT = 8'h2E;

   localparam logic [15:0] LINES_MAX = 16'hFFFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TOP_ENABLE     = 1'b0,
      CSR_TOP_BODY_LINES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BURST_DEPTH-1:0][7:0] bytes;
      logic [COUNT_WIDTH-1:0]      count;
      logic                        term;
   } burst_type;

endpackage

[hdl/dotstf_encoder.sv]
// ----------------------------------------------------------------------------
// dotstf_encoder
// Line state, TOP cut logic and configuration registers. Turns one accepted
// item into a burst of up to seven framed output bytes.
// ----------------------------------------------------------------------------
module dotstf_encoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [7:0]                            data_byte,
   input  logic                                  end_of_message,
   input  logic                                  csr_write_enable,
   input  logic [dotstf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dotstf_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output dotstf_pkg::burst_type                 burst
);
   import dotstf_pkg::*;

   logic        top_enable_ff;
   logic [15:0] top_lines_ff;
   logic        line_start_ff, line_start_in;
   logic        in_headers_ff, in_headers_in;
   logic [15:0] lines_sent_ff, lines_sent_in;
   logic        cut_ff, cut_in;

   logic        is_lf;
   logic        is_dot;
   logic        body_start;
   logic        do_cut;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_enable_ff <= 1'b0;
         top_lines_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TOP_ENABLE:     top_enable_ff <= csr_write_data[0];
            CSR_TOP_BODY_LINES: top_lines_ff  <= csr_write_data[15:0];
            default:            top_enable_ff <= top_enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         in_headers_ff <= 1'b1;
         lines_sent_ff <= '0;
         cut_ff        <= 1'b0;
      end else if (accept) begin
         line_start_ff <= line_start_in;
         in_headers_ff <= in_headers_in;
         lines_sent_ff <= lines_sent_in;
         cut_ff        <= cut_in;
      end
   end

   assign is_lf      = (data_byte == CHAR_LF);
   assign is_dot     = (data_byte == CHAR_DOT);
   assign body_start = line_start_ff && !in_headers_ff;
   assign do_cut     = body_start && top_enable_ff && (lines_sent_ff >= top_lines_ff);

   always_comb begin
      line_start_in = line_start_ff;
      in_headers_in = in_headers_ff;
      lines_sent_in = lines_sent_ff;
      cut_in        = cut_ff;
      burst         = '0;
      if (end_of_message) begin
         line_start_in = 1'b1;
         in_headers_in = 1'b1;
         lines_sent_in = '0;
         cut_in        = 1'b0;
         if (!cut_ff) begin
            burst.term = 1'b1;
            if (line_start_ff) begin
               burst.bytes[0] = CHAR_CR;
               burst.bytes[1] = CHAR_LF;
               burst.bytes[2] = CHAR_DOT;
               burst.bytes[3] = CHAR_CR;
               burst.bytes[4] = CHAR_LF;
               burst.count    = COUNT_WIDTH'(5);
            end else begin
               burst.bytes[0] = CHAR_CR;
               burst.bytes[1] = CHAR_LF;
               burst.bytes[2] = CHAR_CR;
               burst.bytes[3] = CHAR_LF;
               burst.bytes[4] = CHAR_DOT;
               burst.bytes[5] = CHAR_CR;
               burst.bytes[6] = CHAR_LF;
               burst.count    = COUNT_WIDTH'(7);
            end
         end
      end else if (cut_ff) begin
         burst.count = '0;
      end else if (do_cut) begin
         cut_in         = 1'b1;
         burst.term     = 1'b1;
         burst.bytes[0] = CHAR_CR;
         burst.bytes[1] = CHAR_LF;
         burst.bytes[2] = CHAR_DOT;
         burst.bytes[3] = CHAR_CR;
         burst.bytes[4] = CHAR_LF;
         burst.count    = COUNT_WIDTH'(5);
      end else begin
         if (body_start && (lines_sent_ff != LINES_MAX)) begin
            lines_sent_in = lines_sent_ff + 16'd1;
         end
         if (line_start_ff && is_lf && in_headers_ff) begin
            in_headers_in = 1'b0;
         end
         line_start_in = is_lf;
         if (line_start_ff && is_dot) begin
            burst.bytes[0] = CHAR_DOT;
            burst.bytes[1] = CHAR_DOT;
            burst.count    = COUNT_WIDTH'(2);
         end else if (is_lf) begin
            burst.bytes[0] = CHAR_CR;
            burst.bytes[1] = CHAR_LF;
            burst.count    = COUNT_WIDTH'(2);
         end else begin
            burst.bytes[0] = data_byte;
            burst.count    = COUNT_WIDTH'(1);
         end
      end
   end

   a_cut_after_headers: assert property (@(posedge clock) disable iff (reset)
      cut_ff |-> !in_headers_ff)
      else $error("cut reached while still in headers");

   a_cut_needs_top: assert property (@(posedge clock) disable iff (reset)
      (accept && !end_of_message && !cut_ff && !top_enable_ff) |=> !cut_ff)
      else $error("cut taken with top mode off");

endmodule

[hdl/dotstf_serializer.sv]
// ----------------------------------------------------------------------------
// dotstf_serializer
// Result register: holds one burst and sends its bytes one per transfer.
// Takes the next burst in the cycle the last byte goes out.
// ----------------------------------------------------------------------------
module dotstf_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  dotstf_pkg::burst_type burst,
   output logic                  load_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_of_message
);
   import dotstf_pkg::*;

   burst_type              burst_ff;
   logic                   busy_ff, busy_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                   at_end;
   logic                   xfer;

   assign at_end     = (COUNT_WIDTH'(idx_ff) == COUNT_WIDTH'(burst_ff.count - COUNT_WIDTH'(1)));
   assign xfer       = busy_ff && rsp_ready;
   assign load_ready = !busy_ff || (rsp_ready && at_end);

   assign rsp_valid           = busy_ff;
   assign rsp_out_byte        = burst_ff.bytes[idx_ff];
   assign rsp_last_of_message = burst_ff.term && at_end;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = (burst.count != '0);
         idx_in  = '0;
      end else if (xfer) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + INDEX_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (COUNT_WIDTH'(idx_ff) < burst_ff.count))
      else $error("byte index past burst count");

   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_message) |-> (rsp_out_byte == CHAR_LF))
      else $error("last byte of message is not LF");

   a_no_load_midburst: assert property (@(posedge clock) disable iff (reset)
      (load && busy_ff) |-> (rsp_ready && at_end))
      else $error("burst overwritten before it was sent");

endmodule

[hdl/pop3_dot_stuffing_line_encoder.sv]
// ----------------------------------------------------------------------------
// pop3_dot_stuffing_line_encoder
// Frames raw message bytes as a POP3 stream: LF to CR LF, leading dot
// doubled, optional TOP body-line cut, CR LF . CR LF terminator.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     data_byte, end_of_message
//   rsp      out        rsp_valid / rsp_ready     out_byte, last_of_message
//   csr      in         csr_write_enable          csr_index, csr_write_data
//
// An item causes 0 to 7 output bytes, one byte per rsp transfer: plain
// bytes 1, LF or leading dot 2, the terminator 5 or 7. The next item is
// taken in the cycle the last byte of the current burst transfers; items
// with no output leave the encoder ready for the next item.
// Reset is synchronous and clears line state, the cut flag and registers.
// ----------------------------------------------------------------------------
module pop3_dot_stuffing_line_encoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_end_of_message,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_last_of_message,
   input  logic                                  csr_write_enable,
   input  logic [dotstf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dotstf_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import dotstf_pkg::*;

   burst_type burst;
   logic      accept;

   assign accept = req_valid && req_ready;

   dotstf_encoder u_encoder (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .end_of_message   (req_end_of_message),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .burst            (burst)
   );

   dotstf_serializer u_serializer (
      .clock               (clock),
      .reset               (reset),
      .load                (accept),
      .burst               (burst),
      .load_ready          (req_ready),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_message (rsp_last_of_message)
   );

endmodule
